// ===== hw/rtl/handle_table_allocator_assert.svh =====
// Assertion macros for the handle table allocator.
// Each macro expects clk_i and rst_ni in scope.
`ifndef HANDLE_TABLE_ALLOCATOR_ASSERT_SVH
`define HANDLE_TABLE_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HTA_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle table allocator check failed");
`define HTA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle table allocator check failed");
`else
`define HTA_ASSERT_SAME(name, ante, cons)
`define HTA_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hw/rtl/hta_pkg.sv =====
`default_nettype none

package hta_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned DIST_W   = 10;
  localparam int unsigned HIN_W    = 9;
  localparam int unsigned HOUT_W   = 8;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned CHUNK_LG = 3;
  localparam int unsigned CHUNK    = 1 << CHUNK_LG;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_LOOKUP   = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic exec;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic free_found;
    logic last_chunk;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hta_ctrl.sv =====
`default_nettype none

module hta_ctrl import hta_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [CMD_W-1:0] cmd_i,
  input  wire sts_t             sts_i,
  output ctl_t                  ctl_o,
  output logic                  busy_o,
  output logic                  done_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = (cmd_e'(cmd_i) == CMD_REGISTER) ? ST_SCAN : ST_EXEC;
        end
      end
      ST_SCAN: begin
        ctl_o.scan = 1'b1;
        if (sts_i.free_found || sts_i.last_chunk) begin
          state_d = ST_RESP;
        end
      end
      ST_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = ST_RESP;
      end
      ST_RESP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule

`default_nettype wire

// ===== hw/rtl/hta_datapath.sv =====
`default_nettype none

module hta_datapath import hta_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctl_t              ctl_i,
  output sts_t                   sts_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CODE_W-1:0] code_ident_i,
  input  wire logic [DIST_W-1:0] code_distance_i,
  input  wire logic [HIN_W-1:0]  handle_in_i,
  output logic                   ok_o,
  output logic [HOUT_W-1:0]      handle_out_o,
  output logic [CODE_W-1:0]      code_out_o,
  output logic [DIST_W-1:0]      distance_out_o,
  output logic [CNT_W-1:0]       live_count_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned NCH    = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int unsigned NCH_W  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned PAD    = NCH * CHUNK;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DIST_W-1:0] distance;
  } entry_t;

  cmd_e              cmd_q;
  logic [CODE_W-1:0] code_q;
  logic [DIST_W-1:0] dist_q;
  logic [HIN_W-1:0]  hin_q;

  logic [NCH_W-1:0]  chunk_q, chunk_d;
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ok_q, ok_d;
  logic [HOUT_W-1:0] hout_q, hout_d;

  entry_t            mem_q [SLOTS];
  entry_t            rd_q;
  logic              mem_we;

  logic [NCH-1:0][CHUNK-1:0] busy_pad;
  logic [CHUNK-1:0]          chunk_bits;
  logic                      found;
  logic [CHUNK_LG-1:0]       off;
  logic [SLOT_W-1:0]         fslot;
  logic [SLOT_W-1:0]         hidx;
  logic                      in_range;
  logic                      hit;

  // padding past the last slot reads as occupied
  for (genvar g = 0; g < PAD; g++) begin : g_pad
    if (g < SLOTS) begin : g_slot
      assign busy_pad[g / CHUNK][g % CHUNK] = valid_q[g];
    end else begin : g_fill
      assign busy_pad[g / CHUNK][g % CHUNK] = 1'b1;
    end
  end

  assign chunk_bits = busy_pad[chunk_q];

  always_comb begin
    found = 1'b0;
    off   = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (!chunk_bits[i]) begin
        found = 1'b1;
        off   = CHUNK_LG'(i);
      end
    end
  end

  assign fslot    = SLOT_W'({chunk_q, off});
  assign in_range = (32'(hin_q) < SLOTS);
  assign hidx     = SLOT_W'(hin_q);
  assign hit      = in_range && valid_q[hidx];

  assign sts_o.free_found = found;
  assign sts_o.last_chunk = (chunk_q == NCH_W'(NCH - 1));

  always_comb begin
    chunk_d = chunk_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    ok_d    = ok_q;
    hout_d  = hout_q;
    mem_we  = 1'b0;
    if (ctl_i.load) begin
      chunk_d = '0;
    end else if (ctl_i.scan) begin
      if (found) begin
        valid_d[fslot] = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        ok_d           = 1'b1;
        hout_d         = HOUT_W'(fslot);
        mem_we         = 1'b1;
      end else begin
        chunk_d = chunk_q + NCH_W'(1);
        ok_d    = 1'b0;
        hout_d  = '0;
      end
    end else if (ctl_i.exec) begin
      hout_d = '0;
      unique case (cmd_q)
        CMD_LOOKUP: begin
          ok_d = hit;
        end
        CMD_RELEASE: begin
          ok_d = hit;
          if (hit) begin
            valid_d[hidx] = 1'b0;
            cnt_d         = cnt_q - CNT_W'(1);
          end
        end
        CMD_CLEAR: begin
          ok_d    = 1'b1;
          valid_d = '0;
          cnt_d   = '0;
        end
        default: begin
          ok_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      valid_q <= '0;
      cnt_q   <= '0;
    end else begin
      chunk_q <= chunk_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_e'(cmd_i);
      code_q <= code_ident_i;
      dist_q <= code_distance_i;
      hin_q  <= handle_in_i;
    end
    ok_q   <= ok_d;
    hout_q <= hout_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[fslot] <= '{code: code_q, distance: dist_q};
    end
    rd_q <= mem_q[hidx];
  end

  assign ok_o           = ok_q;
  assign handle_out_o   = hout_q;
  assign code_out_o     = (ok_q && cmd_q == CMD_LOOKUP) ? rd_q.code : '0;
  assign distance_out_o = (ok_q && cmd_q == CMD_LOOKUP) ? rd_q.distance : '0;
  assign live_count_o   = cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/handle_table_allocator.sv =====
// Channel   Handshake                     Payload
// command   start_i in, busy_o out        cmd_i code_ident_i code_distance_i handle_in_i
// result    done_o out, one-cycle strobe  ok_o handle_out_o code_out_o distance_out_o
//                                         live_count_o
//
// Lookup, release and clear: ST_EXEC, then the result strobe in ST_RESP.
// Register: ST_SCAN, then the strobe in ST_RESP; the free-slot scan tests eight
// valid bits per cycle starting from the lowest slot, up to the last chunk.
// busy_o drops after done_o.
// Reset clears all valid bits and the live count at once; no sweep follows.
// The result strobe cannot be stalled.
`default_nettype none

module handle_table_allocator import hta_pkg::*; #(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CODE_W-1:0] code_ident_i,
  input  wire logic [DIST_W-1:0] code_distance_i,
  input  wire logic [HIN_W-1:0]  handle_in_i,
  output logic                   done_o,
  output logic                   ok_o,
  output logic [HOUT_W-1:0]      handle_out_o,
  output logic [CODE_W-1:0]      code_out_o,
  output logic [DIST_W-1:0]      distance_out_o,
  output logic [CNT_W-1:0]       live_count_o
);

  `include "handle_table_allocator_assert.svh"

  ctl_t ctl;
  sts_t sts;

  hta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  hta_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .cmd_i           (cmd_i),
    .code_ident_i    (code_ident_i),
    .code_distance_i (code_distance_i),
    .handle_in_i     (handle_in_i),
    .ok_o            (ok_o),
    .handle_out_o    (handle_out_o),
    .code_out_o      (code_out_o),
    .distance_out_o  (distance_out_o),
    .live_count_o    (live_count_o)
  );

  `HTA_ASSERT_SAME(a_done_while_busy, done_o, busy_o)
  `HTA_ASSERT_NEXT(a_transfer_sets_busy, start_i && !busy_o, busy_o && !done_o)
  `HTA_ASSERT_NEXT(a_idle_after_done, done_o, !busy_o)
  `HTA_ASSERT_SAME(a_count_bound, 1'b1, 32'(live_count_o) <= SLOTS)

endmodule

`default_nettype wire

// ===== test/handle_table_checker.sv =====
`default_nettype none

module handle_table_checker
  import hta_pkg::*;
#(
  parameter int unsigned SLOTS = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [CMD_W-1:0]  cmd_i,
  input  wire logic [CODE_W-1:0] code_ident_i,
  input  wire logic [DIST_W-1:0] code_distance_i,
  input  wire logic [HIN_W-1:0]  handle_in_i,
  input  wire logic              done_i,
  input  wire logic              ok_i,
  input  wire logic [HOUT_W-1:0] handle_out_i,
  input  wire logic [CODE_W-1:0] code_out_i,
  input  wire logic [DIST_W-1:0] distance_out_i,
  input  wire logic [CNT_W-1:0]  live_count_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic              ok;
    logic [HOUT_W-1:0] handle;
    logic [CODE_W-1:0] code;
    logic [DIST_W-1:0] distance;
    logic [CNT_W-1:0]  live;
  } reply_t;

  logic              tbl_valid [SLOTS];
  logic [CODE_W-1:0] tbl_code  [SLOTS];
  logic [DIST_W-1:0] tbl_dist  [SLOTS];
  logic [CNT_W-1:0]  tbl_live;
  reply_t            replies_due [$];
  int unsigned       fails = 0;

  assign fail_count_o = fails;

  function automatic reply_t apply_command(cmd_e op, logic [CODE_W-1:0] code,
                                           logic [DIST_W-1:0] distance,
                                           logic [HIN_W-1:0] h);
    reply_t r;
    int     slot;
    r    = '0;
    slot = -1;
    case (op)
      CMD_REGISTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!tbl_valid[i] && slot < 0) slot = i;
        end
        if (slot >= 0) begin
          tbl_valid[slot] = 1'b1;
          tbl_code[slot]  = code;
          tbl_dist[slot]  = distance;
          tbl_live        = tbl_live + CNT_W'(1);
          r.ok            = 1'b1;
          r.handle        = HOUT_W'(slot);
        end
      end
      CMD_LOOKUP: begin
        if (h < SLOTS && tbl_valid[h]) begin
          r.ok       = 1'b1;
          r.code     = tbl_code[h];
          r.distance = tbl_dist[h];
        end
      end
      CMD_RELEASE: begin
        if (h < SLOTS && tbl_valid[h]) begin
          tbl_valid[h] = 1'b0;
          tbl_live     = tbl_live - CNT_W'(1);
          r.ok         = 1'b1;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        tbl_live = '0;
        r.ok     = 1'b1;
      end
    endcase
    r.live = tbl_live;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_valid[i] = 1'b0;
        tbl_code[i]  = '0;
        tbl_dist[i]  = '0;
      end
      tbl_live = '0;
      replies_due.delete();
      pending_o <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (replies_due.size() == 0) begin
          $error("result strobe with no transfer outstanding");
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (ok_i !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, ok_i);
            fails++;
          end
          if (handle_out_i !== want.handle) begin
            $error("handle_out: expected %0d, got %0d", want.handle, handle_out_i);
            fails++;
          end
          if (code_out_i !== want.code) begin
            $error("code_out: expected %h, got %h", want.code, code_out_i);
            fails++;
          end
          if (distance_out_i !== want.distance) begin
            $error("distance_out: expected %0d, got %0d", want.distance, distance_out_i);
            fails++;
          end
          if (live_count_i !== want.live) begin
            $error("live_count: expected %0d, got %0d", want.live, live_count_i);
            fails++;
          end
        end
      end
      if (start_i === 1'b1 && busy_i === 1'b0) begin
        replies_due.push_back(apply_command(cmd_e'(cmd_i), code_ident_i,
                                            code_distance_i, handle_in_i));
      end
      pending_o <= replies_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hta_pkg::*;

  localparam int NSLOTS = 256;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [CMD_W-1:0]  cmd_i = '0;
  logic [CODE_W-1:0] code_ident_i = '0;
  logic [DIST_W-1:0] code_distance_i = '0;
  logic [HIN_W-1:0]  handle_in_i = '0;
  logic              busy_o;
  logic              done_o;
  logic              ok_o;
  logic [HOUT_W-1:0] handle_out_o;
  logic [CODE_W-1:0] code_out_o;
  logic [DIST_W-1:0] distance_out_o;
  logic [CNT_W-1:0]  live_count_o;
  int unsigned       fail_count;
  int unsigned       pending;

  // stimulus-side view of which handles are taken
  logic [NSLOTS-1:0] held = '0;
  int                held_n = 0;
  int                idle_pct = 0;

  handle_table_allocator #(.SLOTS(NSLOTS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .code_ident_i   (code_ident_i),
    .code_distance_i(code_distance_i),
    .handle_in_i    (handle_in_i),
    .done_o         (done_o),
    .ok_o           (ok_o),
    .handle_out_o   (handle_out_o),
    .code_out_o     (code_out_o),
    .distance_out_o (distance_out_o),
    .live_count_o   (live_count_o)
  );

  handle_table_checker #(.SLOTS(NSLOTS)) u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .cmd_i          (cmd_i),
    .code_ident_i   (code_ident_i),
    .code_distance_i(code_distance_i),
    .handle_in_i    (handle_in_i),
    .done_i         (done_o),
    .ok_i           (ok_o),
    .handle_out_i   (handle_out_o),
    .code_out_i     (code_out_o),
    .distance_out_i (distance_out_o),
    .live_count_i   (live_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int first_free();
    for (int i = 0; i < NSLOTS; i++) begin
      if (!held[i]) return i;
    end
    return -1;
  endfunction

  function automatic logic [HIN_W-1:0] pick_handle();
    int r;
    int base;
    r    = $urandom_range(0, 99);
    base = $urandom_range(0, NSLOTS - 1);
    if (r < 70 && held_n > 0) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (held[(base + i) % NSLOTS]) return HIN_W'((base + i) % NSLOTS);
      end
    end
    if (r < 85) return HIN_W'(base);
    return HIN_W'($urandom_range(NSLOTS, 511));
  endfunction

  task automatic issue(cmd_e op, logic [CODE_W-1:0] code, logic [DIST_W-1:0] distance,
                       logic [HIN_W-1:0] h);
    int slot;
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i         <= 1'b1;
    cmd_i           <= op;
    code_ident_i    <= code;
    code_distance_i <= distance;
    handle_in_i     <= h;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    case (op)
      CMD_REGISTER: begin
        slot = first_free();
        if (slot >= 0) begin
          held[slot] = 1'b1;
          held_n++;
        end
      end
      CMD_RELEASE: begin
        if (h < NSLOTS && held[h]) begin
          held[h] = 1'b0;
          held_n--;
        end
      end
      CMD_CLEAR: begin
        held   = '0;
        held_n = 0;
      end
      default: ;
    endcase
  endtask

  task automatic random_item(int reg_pct, int clr_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < clr_pct)
      issue(CMD_CLEAR, CODE_W'($urandom), DIST_W'($urandom), pick_handle());
    else if (r < clr_pct + reg_pct)
      issue(CMD_REGISTER, CODE_W'($urandom), DIST_W'($urandom), HIN_W'($urandom));
    else if ($urandom_range(0, 1) == 0)
      issue(CMD_LOOKUP, CODE_W'($urandom), DIST_W'($urandom), pick_handle());
    else
      issue(CMD_RELEASE, CODE_W'($urandom), DIST_W'($urandom), pick_handle());
  endtask

  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, unused and out-of-range handles
    issue(CMD_LOOKUP,   16'h1234, 10'h155, 9'd0);
    issue(CMD_RELEASE,  16'h4321, 10'h2aa, 9'd0);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd511);
    issue(CMD_RELEASE,  16'hffff, 10'h3ff, 9'd256);
    // payload extremes
    issue(CMD_REGISTER, 16'hffff, 10'h3ff, 9'd0);
    issue(CMD_REGISTER, 16'h0000, 10'h000, 9'd511);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd0);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd1);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd255);
    // freed slot is reused first
    issue(CMD_RELEASE,  16'h0000, 10'h000, 9'd0);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd0);
    issue(CMD_REGISTER, 16'ha5a5, 10'h2aa, 9'd0);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd0);
    issue(CMD_RELEASE,  16'h0000, 10'h000, 9'd1);
    issue(CMD_RELEASE,  16'h0000, 10'h000, 9'd1);
    // clear all
    issue(CMD_CLEAR,    16'h5a5a, 10'h155, 9'd0);
    issue(CMD_LOOKUP,   16'h0000, 10'h000, 9'd0);
    issue(CMD_REGISTER, 16'h8001, 10'h201, 9'd0);
    issue(CMD_CLEAR,    16'h0000, 10'h000, 9'd511);
    issue(CMD_RELEASE,  16'h0000, 10'h000, 9'd511);

    // fill the table up, then hit it while full
    idle_pct = 33;
    while (held_n < NSLOTS) random_item(90, 0);
    repeat (6) issue(CMD_REGISTER, CODE_W'($urandom), DIST_W'($urandom), HIN_W'($urandom));
    repeat (20) random_item(40, 0);
    drain();

    idle_pct = 72;
    repeat (110) random_item(10, 1);
    drain();

    idle_pct = 0;
    repeat (100) random_item(35, 3);

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hta_pkg.sv
hw/rtl/hta_ctrl.sv
hw/rtl/hta_datapath.sv
hw/rtl/handle_table_allocator.sv
test/handle_table_checker.sv
test/tb.sv
